// ----- hw/rtl/roof_vent_controller_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the roof vent controller
// Clocked concurrent assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ROOF_VENT_CONTROLLER_MACROS_SVH
`define ROOF_VENT_CONTROLLER_MACROS_SVH

// Assert prop on every rising clock edge, held off while reset is low.
`define RVC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assert prop on every rising clock edge, reset included.
`define RVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rvc_pkg.sv -----
// ---------------------------------------------------------------------------
// rvc_pkg
// Codes, widths and register map of the roof vent controller.
// ---------------------------------------------------------------------------
package rvc_pkg;

	// roof states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CLOSED  = 3'd1;
	localparam logic [2:0] ST_OPENING = 3'd2;
	localparam logic [2:0] ST_OPEN    = 3'd3;
	localparam logic [2:0] ST_CLOSING = 3'd4;
	localparam logic [2:0] ST_ERROR   = 3'd5;

	// motor commands
	localparam logic [1:0] MC_NONE  = 2'd0;
	localparam logic [1:0] MC_OPEN  = 2'd1;
	localparam logic [1:0] MC_CLOSE = 2'd2;
	localparam logic [1:0] MC_STOP  = 2'd3;

	// input commands
	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_INIT   = 3'd1;
	localparam logic [2:0] CMD_SYNC   = 3'd2;
	localparam logic [2:0] CMD_FORCE  = 3'd3;
	localparam logic [2:0] CMD_ACK    = 3'd4;

	// register indexes
	localparam logic [2:0] REG_TEMP_TARGET   = 3'd0;
	localparam logic [2:0] REG_TEMP_HYST     = 3'd1;
	localparam logic [2:0] REG_OPEN_PWM      = 3'd2;
	localparam logic [2:0] REG_CLOSE_PWM     = 3'd3;
	localparam logic [2:0] REG_OPEN_DURATION = 3'd4;
	localparam logic [2:0] REG_CLOSE_TIMEOUT = 3'd5;
	localparam logic [2:0] REG_MIN_DWELL     = 3'd6;
	localparam logic [2:0] REG_STALE_TIMEOUT = 3'd7;

	localparam logic [31:0] REED_GRACE_MS = 32'd3000;

	localparam int IN_W  = 88;
	localparam int OUT_W = 16;

	// result beat layout, low bit of each field
	localparam int OUT_STATE_LSB = 0;
	localparam int OUT_MCMD_LSB  = 3;
	localparam int OUT_LEVEL_LSB = 5;
	localparam int OUT_TERR_BIT  = 13;
	localparam int OUT_STALE_BIT = 14;
	localparam int OUT_REED_BIT  = 15;

endpackage

// ----- hw/rtl/roof_vent_controller.sv -----
// ---------------------------------------------------------------------------
// roof_vent_controller
// Six-state motorized vent roof controller with APB register access.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, with the command code in
//   s_tuser. Each input beat yields exactly one result beat on
//   m_tvalid/m_tready/m_tdata.
//   The result beat passes through one input register, then the state update
//   and result register. Throughput is one beat per cycle while m_tready
//   stays high; the state registers close a loop through the compare and
//   subtract logic.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more beat, then s_tready drops until the result
//   is taken.
//   Reset returns the roof to idle with all flags clear and loads the
//   register defaults. The user must write registers through the APB port
//   only while no beat is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module roof_vent_controller (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms[31:0], temperature[46:32], reed_closed[47], last_read_ms[79:48],
	// forced_state[82:80], zero[87:83]
	input  logic [rvc_pkg::IN_W-1:0] s_tdata,
	// command[2:0]
	input  logic [2:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// roof_state[2:0], motor_command[4:3], motor_level[12:5], timeout_error[13],
	// sensor_stale[14], reed_warning[15]
	output logic [rvc_pkg::OUT_W-1:0] m_tdata
);

	// configuration registers
	logic signed [14:0] temp_target_q;
	logic [10:0] temp_hyst_q;
	logic [7:0]  open_pwm_q;
	logic [7:0]  close_pwm_q;
	logic [31:0] open_duration_q;
	logic [31:0] close_timeout_q;
	logic [31:0] min_dwell_q;
	logic [31:0] stale_timeout_q;

	// controller state
	logic [2:0]  state_q;
	logic [31:0] entered_q;
	logic        reed_warned_q;
	logic        stale_q;
	logic        error_q;

	// input register
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [rvc_pkg::IN_W-1:0] data_s1;

	// result register
	logic        m_tvalid_q;
	logic [rvc_pkg::OUT_W-1:0] m_tdata_q;

	logic        advance;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign cfg_idx  = paddr[4:2];
	assign advance  = valid_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		case (cfg_idx)
			rvc_pkg::REG_TEMP_TARGET:   prdata = {{17{temp_target_q[14]}}, temp_target_q};
			rvc_pkg::REG_TEMP_HYST:     prdata = {21'd0, temp_hyst_q};
			rvc_pkg::REG_OPEN_PWM:      prdata = {24'd0, open_pwm_q};
			rvc_pkg::REG_CLOSE_PWM:     prdata = {24'd0, close_pwm_q};
			rvc_pkg::REG_OPEN_DURATION: prdata = open_duration_q;
			rvc_pkg::REG_CLOSE_TIMEOUT: prdata = close_timeout_q;
			rvc_pkg::REG_MIN_DWELL:     prdata = min_dwell_q;
			rvc_pkg::REG_STALE_TIMEOUT: prdata = stale_timeout_q;
			default:                    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_target_q   <= 15'sd2500;
			temp_hyst_q     <= 11'd200;
			open_pwm_q      <= 8'd255;
			close_pwm_q     <= 8'd255;
			open_duration_q <= 32'd20000;
			close_timeout_q <= 32'd30000;
			min_dwell_q     <= 32'd60000;
			stale_timeout_q <= 32'd10000;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rvc_pkg::REG_TEMP_TARGET:   temp_target_q   <= pwdata[14:0];
				rvc_pkg::REG_TEMP_HYST:     temp_hyst_q     <= pwdata[10:0];
				rvc_pkg::REG_OPEN_PWM:      open_pwm_q      <= pwdata[7:0];
				rvc_pkg::REG_CLOSE_PWM:     close_pwm_q     <= pwdata[7:0];
				rvc_pkg::REG_OPEN_DURATION: open_duration_q <= pwdata;
				rvc_pkg::REG_CLOSE_TIMEOUT: close_timeout_q <= pwdata;
				rvc_pkg::REG_MIN_DWELL:     min_dwell_q     <= pwdata;
				rvc_pkg::REG_STALE_TIMEOUT: stale_timeout_q <= pwdata;
				default: ;
			endcase
		end
	end

	// unpack the staged beat
	logic [31:0]        now;
	logic signed [16:0] temp;
	logic               closed;
	logic [31:0]        last_read;
	logic [2:0]         forced;

	assign now       = data_s1[31:0];
	assign temp      = {{2{data_s1[46]}}, data_s1[46:32]};
	assign closed    = data_s1[47];
	assign last_read = data_s1[79:48];
	assign forced    = data_s1[82:80];

	logic [31:0]        elapsed;
	logic [31:0]        age;
	logic               stale;
	logic signed [16:0] target_x;
	logic signed [16:0] hyst_x;
	logic signed [16:0] hi;
	logic signed [16:0] lo;
	logic               dwell_done;

	assign elapsed    = now - entered_q;
	assign age        = now - last_read;
	assign stale      = age > stale_timeout_q;
	assign target_x   = {{2{temp_target_q[14]}}, temp_target_q};
	assign hyst_x     = {6'd0, temp_hyst_q};
	assign hi         = target_x + hyst_x;
	assign lo         = target_x - hyst_x;
	assign dwell_done = elapsed >= min_dwell_q;

	logic [2:0]  state_d;
	logic [31:0] entered_d;
	logic        reed_warned_d;
	logic        stale_d;
	logic        error_d;
	logic [1:0]  mcmd;
	logic [7:0]  level;
	logic        pulse;
	logic        enter;
	logic [2:0]  enter_state;

	always_comb begin
		stale_d       = stale_q;
		error_d       = error_q;
		reed_warned_d = reed_warned_q;
		mcmd          = rvc_pkg::MC_NONE;
		level         = 8'd0;
		pulse         = 1'b0;
		enter         = 1'b0;
		enter_state   = state_q;
		case (cmd_s1)
			rvc_pkg::CMD_UPDATE: begin
				if (state_q != rvc_pkg::ST_ERROR) begin
					stale_d = stale;
					case (state_q)
						rvc_pkg::ST_IDLE, rvc_pkg::ST_CLOSED: begin
							if (stale || (dwell_done && temp > hi)) begin
								mcmd        = rvc_pkg::MC_OPEN;
								level       = open_pwm_q;
								enter       = 1'b1;
								enter_state = rvc_pkg::ST_OPENING;
							end
						end
						rvc_pkg::ST_OPENING: begin
							if (closed && elapsed > rvc_pkg::REED_GRACE_MS && !reed_warned_q) begin
								reed_warned_d = 1'b1;
								pulse         = 1'b1;
							end
							if (elapsed >= open_duration_q) begin
								mcmd        = rvc_pkg::MC_STOP;
								enter       = 1'b1;
								enter_state = rvc_pkg::ST_OPEN;
							end
						end
						rvc_pkg::ST_OPEN: begin
							if (!stale && dwell_done && temp < lo) begin
								mcmd        = rvc_pkg::MC_CLOSE;
								level       = close_pwm_q;
								enter       = 1'b1;
								enter_state = rvc_pkg::ST_CLOSING;
							end
						end
						rvc_pkg::ST_CLOSING: begin
							if (closed) begin
								mcmd        = rvc_pkg::MC_STOP;
								enter       = 1'b1;
								enter_state = rvc_pkg::ST_CLOSED;
							end else if (elapsed >= close_timeout_q) begin
								mcmd        = rvc_pkg::MC_STOP;
								error_d     = 1'b1;
								enter       = 1'b1;
								enter_state = rvc_pkg::ST_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
			rvc_pkg::CMD_INIT, rvc_pkg::CMD_SYNC: begin
				enter       = 1'b1;
				enter_state = closed ? rvc_pkg::ST_CLOSED : rvc_pkg::ST_OPEN;
			end
			rvc_pkg::CMD_FORCE: begin
				if (forced <= rvc_pkg::ST_ERROR) begin
					enter       = 1'b1;
					enter_state = forced;
				end
			end
			rvc_pkg::CMD_ACK: begin
				if (state_q == rvc_pkg::ST_ERROR) begin
					error_d     = 1'b0;
					enter       = 1'b1;
					enter_state = rvc_pkg::ST_IDLE;
				end
			end
			default: ;
		endcase

		state_d   = enter_state;
		entered_d = entered_q;
		if (enter) begin
			entered_d     = now;
			reed_warned_d = 1'b0;
		end
		// sync pre-ages the dwell so a temperature stroke may follow at once
		if (cmd_s1 == rvc_pkg::CMD_SYNC) begin
			entered_d = now - min_dwell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rvc_pkg::ST_IDLE;
			entered_q     <= 32'd0;
			reed_warned_q <= 1'b0;
			stale_q       <= 1'b0;
			error_q       <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (advance) begin
				state_q       <= state_d;
				entered_q     <= entered_d;
				reed_warned_q <= reed_warned_d;
				stale_q       <= stale_d;
				error_q       <= error_d;
				m_tvalid_q    <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {pulse, stale_d, error_d, level, mcmd, state_d};
		end
	end

endmodule

// ----- hw/rtl/rvc_checker.sv -----
// ---------------------------------------------------------------------------
// rvc_checker
// Port-level checks on the result stream of the roof vent controller.
// ---------------------------------------------------------------------------
`include "roof_vent_controller_macros.svh"

module rvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [rvc_pkg::OUT_W-1:0] m_tdata
);

	logic [2:0] roof_state;
	logic [1:0] mcmd;
	logic [7:0] level;
	logic       reed;

	assign roof_state = m_tdata[rvc_pkg::OUT_STATE_LSB +: 3];
	assign mcmd       = m_tdata[rvc_pkg::OUT_MCMD_LSB +: 2];
	assign level      = m_tdata[rvc_pkg::OUT_LEVEL_LSB +: 8];
	assign reed       = m_tdata[rvc_pkg::OUT_REED_BIT];

	// a stalled beat holds
	`RVC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")

	// drive level only rides on a start command
	`RVC_ASSERT(a_level_zero, clk, arst_n, m_tvalid && (mcmd == rvc_pkg::MC_NONE || mcmd == rvc_pkg::MC_STOP) |-> level == 8'd0, "motor level set without a start command")

	// an open start command lands in the opening state
	`RVC_ASSERT(a_start_state, clk, arst_n, m_tvalid && mcmd == rvc_pkg::MC_OPEN |-> roof_state == rvc_pkg::ST_OPENING, "open start outside the opening state")

	// the reed warning fires only in an opening stroke or as it ends
	`RVC_ASSERT(a_reed_state, clk, arst_n, m_tvalid && reed |-> roof_state == rvc_pkg::ST_OPENING || roof_state == rvc_pkg::ST_OPEN, "reed warning outside an opening stroke")

endmodule

bind roof_vent_controller rvc_checker u_rvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
